[sv/nibble_rle_line_decoder_macros.svh]
// Assertion macros for the nibble RLE line decoder
`ifndef NIBBLE_RLE_LINE_DECODER_MACROS_SVH
`define NIBBLE_RLE_LINE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define NRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define NRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)

`define NRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[sv/nrle_pkg.sv]
// Types, codes and constants shared by the nibble RLE line decoder
package nrle_pkg;

  localparam logic [15:0] LINE_PIXELS_RST = 16'd4096;
  localparam int unsigned RESULT_QUEUE_DEPTH = 4;

  localparam logic [3:0] OP_EOL      = 4'd0;
  localparam logic [3:0] OP_TEXT     = 4'd1;
  localparam logic [3:0] OP_INSTR    = 4'd2;
  localparam logic [3:0] OP_RUN2     = 4'd4;
  localparam logic [3:0] OP_RUN3     = 4'd5;
  localparam logic [3:0] OP_RUN4     = 4'd6;
  localparam logic [3:0] OP_RUN5     = 4'd7;
  localparam logic [3:0] OP_RUN6     = 4'd8;
  localparam logic [3:0] OP_RUN7     = 4'd9;
  localparam logic [3:0] OP_RUN_LONG = 4'd10;
  localparam logic [3:0] OP_PIXEL    = 4'd11;
  localparam logic [3:0] OP_RAW      = 4'd12;
  localparam logic [3:0] OP_RAW_ODD  = 4'd13;

  // offset between a short-run opcode and its run length
  localparam logic [8:0] RUN_OP_BIAS = 9'd2;
  // bytes of an instrument record: four line-number bytes, then four word bytes
  localparam logic [10:0] INSTR_BYTES = 11'd8;
  localparam logic [10:0] INSTR_WORD_BYTES = 11'd4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TEXT_LEN,
    PH_TEXT,
    PH_INSTR,
    PH_RUN_LEN,
    PH_RAW_ODD,
    PH_RAW
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_EOL,
    KIND_TEXT,
    KIND_INSTR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pixel_value;
    logic [8:0]  repeat_count;
    logic [7:0]  text_char;
    logic        text_last;
    logic [3:0]  instrument_id;
    logic [31:0] scan_line_number;
    logic [31:0] data_word;
    logic        overflow;
  } res_t;

  // up to two results per request, r0 first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_LINE_PIXELS = 1'b0;

endpackage

[sv/nrle_cfg.sv]
// APB register block holding the line width
module nrle_cfg
  import nrle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [15:0]           line_pixels
);

  logic [15:0] line_pixels_r;
  logic [15:0] line_pixels_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == CFG_IDX_LINE_PIXELS);

  always_comb begin
    line_pixels_nxt = line_pixels_r;
    if (wr_en) begin
      line_pixels_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pixels_r <= LINE_PIXELS_RST;
    end else begin
      line_pixels_r <= line_pixels_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_IDX_LINE_PIXELS) begin
      prdata = {16'd0, line_pixels_r};
    end
  end

  assign line_pixels = line_pixels_r;

endmodule

[sv/nrle_parser.sv]
// Byte parser: parse state registers and the single-pass decode of one byte
module nrle_parser
  import nrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic [15:0] line_pixels,
  output res_pair_t  results
);

  typedef struct packed {
    res_t        r;
    logic [15:0] lc;
  } place_t;

  phase_t      phase_r,  phase_nxt;
  logic [3:0]  hnib_r,   hnib_nxt;
  logic [10:0] brem_r,   brem_nxt;
  logic [15:0] lcnt_r,   lcnt_nxt;
  logic [3:0]  held_id_r, held_id_nxt;
  logic [31:0] ln_r,     ln_nxt;
  logic [31:0] word_r,   word_nxt;
  logic        tfinal_r, tfinal_nxt;

  logic [3:0]  op;
  logic [3:0]  hi;
  logic [10:0] brem_dec;
  logic [15:0] lc_base;
  res_t        ra, rb;
  logic        va, vb;
  place_t      p0, p1;

  function automatic place_t place(input logic [3:0] code, input logic [8:0] cnt,
                                   input logic [15:0] lc, input logic [15:0] lp);
    logic [16:0] sum;
    place_t      p;
    sum = {1'b0, lc} + {8'd0, cnt};
    p = '0;
    p.r.kind = KIND_PIXEL;
    p.r.pixel_value = {code, code};
    p.r.repeat_count = cnt;
    if (sum <= {1'b0, lp}) begin
      p.lc = sum[15:0];
      p.r.overflow = 1'b0;
    end else begin
      p.lc = lc;
      p.r.overflow = 1'b1;
    end
    return p;
  endfunction

  assign op = in_byte[3:0];
  assign hi = in_byte[7:4];
  assign brem_dec = brem_r - 11'd1;

  always_comb begin
    phase_nxt   = phase_r;
    hnib_nxt    = hnib_r;
    brem_nxt    = brem_r;
    lcnt_nxt    = lcnt_r;
    held_id_nxt = held_id_r;
    ln_nxt      = ln_r;
    word_nxt    = word_r;
    tfinal_nxt  = tfinal_r;
    ra = '0;
    rb = '0;
    va = 1'b0;
    vb = 1'b0;
    lc_base = lcnt_r;
    p0 = '0;
    p1 = '0;
    unique case (phase_r)
      PH_HEADER: begin
        // full line: close it before decoding any non-EOL header
        if (op != OP_EOL && lcnt_r >= line_pixels) begin
          va = 1'b1;
          ra.kind = KIND_EOL;
          lc_base = '0;
          lcnt_nxt = '0;
        end
        unique case (op)
          OP_EOL: begin
            vb = 1'b1;
            rb.kind = KIND_EOL;
            lcnt_nxt = '0;
          end
          OP_TEXT: begin
            tfinal_nxt = hi[0];
            hnib_nxt = {1'b0, hi[3:1]};
            phase_nxt = PH_TEXT_LEN;
          end
          OP_INSTR: begin
            held_id_nxt = hi;
            brem_nxt = INSTR_BYTES;
            phase_nxt = PH_INSTR;
          end
          OP_RUN2, OP_RUN3, OP_RUN4, OP_RUN5, OP_RUN6, OP_RUN7: begin
            p1 = place(hi, {5'd0, op} - RUN_OP_BIAS, lc_base, line_pixels);
            vb = 1'b1;
            rb = p1.r;
            lcnt_nxt = p1.lc;
          end
          OP_RUN_LONG: begin
            hnib_nxt = hi;
            phase_nxt = PH_RUN_LEN;
          end
          OP_PIXEL: begin
            p1 = place(hi, 9'd1, lc_base, line_pixels);
            vb = 1'b1;
            rb = p1.r;
            lcnt_nxt = p1.lc;
          end
          OP_RAW: begin
            brem_nxt = {7'd0, hi} + 11'd1;
            phase_nxt = PH_RAW;
          end
          OP_RAW_ODD: begin
            hnib_nxt = hi;
            phase_nxt = PH_RAW_ODD;
          end
          default: ;
        endcase
      end
      PH_TEXT_LEN: begin
        brem_nxt = {hnib_r[2:0], in_byte};
        phase_nxt = ({hnib_r[2:0], in_byte} != 11'd0) ? PH_TEXT : PH_HEADER;
      end
      PH_TEXT: begin
        brem_nxt = brem_dec;
        vb = 1'b1;
        rb.kind = KIND_TEXT;
        rb.text_char = in_byte;
        rb.text_last = (brem_dec == 11'd0) & tfinal_r;
        if (brem_dec == 11'd0) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_INSTR: begin
        if (brem_r > INSTR_WORD_BYTES) begin
          ln_nxt = {in_byte, ln_r[31:8]};
        end else begin
          word_nxt = {in_byte, word_r[31:8]};
        end
        brem_nxt = brem_dec;
        if (brem_dec == 11'd0) begin
          vb = 1'b1;
          rb.kind = KIND_INSTR;
          rb.instrument_id = held_id_r;
          rb.scan_line_number = ln_nxt;
          rb.data_word = word_nxt;
          phase_nxt = PH_HEADER;
        end
      end
      PH_RUN_LEN: begin
        p1 = place(hnib_r, {1'b0, in_byte} + 9'd1, lcnt_r, line_pixels);
        vb = 1'b1;
        rb = p1.r;
        lcnt_nxt = p1.lc;
        phase_nxt = PH_HEADER;
      end
      PH_RAW_ODD: begin
        brem_nxt = 11'd1 + {3'd0, hnib_r, 4'd0} + {7'd0, in_byte[3:0]};
        p1 = place(hi, 9'd1, lcnt_r, line_pixels);
        vb = 1'b1;
        rb = p1.r;
        lcnt_nxt = p1.lc;
        phase_nxt = PH_RAW;
      end
      PH_RAW: begin
        // low nibble first, each pixel clipped on its own
        p0 = place(op, 9'd1, lcnt_r, line_pixels);
        p1 = place(hi, 9'd1, p0.lc, line_pixels);
        va = 1'b1;
        ra = p0.r;
        vb = 1'b1;
        rb = p1.r;
        lcnt_nxt = p1.lc;
        brem_nxt = brem_dec;
        if (brem_dec == 11'd0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_comb begin
    results = '0;
    if (va) begin
      results.r0 = ra;
      results.r1 = rb;
      results.n  = vb ? 2'd2 : 2'd1;
    end else begin
      results.r0 = rb;
      results.n  = {1'b0, vb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hnib_r    <= '0;
      brem_r    <= '0;
      lcnt_r    <= '0;
      held_id_r <= '0;
      ln_r      <= '0;
      word_r    <= '0;
      tfinal_r  <= 1'b0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      hnib_r    <= hnib_nxt;
      brem_r    <= brem_nxt;
      lcnt_r    <= lcnt_nxt;
      held_id_r <= held_id_nxt;
      ln_r      <= ln_nxt;
      word_r    <= word_nxt;
      tfinal_r  <= tfinal_nxt;
    end
  end

endmodule

[sv/nrle_res_queue.sv]
// Result queue: takes up to two results per request, hands out one per cycle while pop is high
module nrle_res_queue
  import nrle_pkg::*;
#(
  parameter int unsigned Depth = RESULT_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  res_pair_t                  wr_data,
  input  logic                       pop,
  output res_t                       head,
  output logic [$clog2(Depth+1)-1:0] level
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned LvlW = $clog2(Depth + 1);

  res_t            slots [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [LvlW-1:0] level_r, level_nxt;
  logic [PtrW-1:0] wr_p1;
  logic [1:0]      n_push;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_p1  = inc(wr_r);
  assign n_push = push ? wr_data.n : 2'd0;

  always_comb begin
    wr_nxt = wr_r;
    unique case (n_push)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = inc(wr_p1);
      default: wr_nxt = wr_r;
    endcase
    rd_nxt = pop ? inc(rd_r) : rd_r;
    level_nxt = level_r + LvlW'(n_push) - LvlW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slots[wr_r] <= wr_data.r0;
    end
    if (n_push == 2'd2) begin
      slots[wr_p1] <= wr_data.r1;
    end
  end

  assign head  = slots[rd_r];
  assign level = level_r;

endmodule

[sv/nibble_rle_line_decoder.sv]
// Top level of the nibble RLE line decoder
//
// Usage: encoded scan-line bytes enter on in_byte with in_valid; a request is
// taken at a clock edge where in_valid is high and in_stall is low. Each byte
// is decoded in the cycle it is taken and yields zero, one or two results
// (end of line, pixel run, text byte, instrument record), which land in a
// four-entry result queue. The queue head drives the out_ ports; a result is
// taken when out_valid is high and out_stall is low.
// A result is registered in the queue when its byte is taken and reaches the outputs at the queue head.
// Throughput: one byte per cycle while the receiver keeps up; the output side
// moves one result per cycle, so bytes that yield two results (raw pixel pairs,
// a header that closes a full line) are limited by that port.
// in_stall rises when fewer than two queue entries are free, so a stalled
// receiver backs up into the input after at most three pending results.
// Reset (rst_n low, synchronous) empties the queue, returns the parser to
// header mode with a zero line count, and sets line_pixels to 4096.
// line_pixels sits at byte address 0 of the APB port.
`include "nibble_rle_line_decoder_macros.svh"

module nibble_rle_line_decoder
  import nrle_pkg::*;
#(
  parameter int unsigned QueueDepth = RESULT_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_pixel_value,
  output logic [8:0]            out_repeat_count,
  output logic [7:0]            out_text_char,
  output logic                  out_text_last,
  output logic [3:0]            out_instrument_id,
  output logic [31:0]           out_scan_line_number,
  output logic [31:0]           out_data_word,
  output logic                  out_overflow,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned LvlW = $clog2(QueueDepth + 1);

  logic            in_acc;
  logic            out_acc;
  logic [15:0]     line_pixels;
  res_pair_t       results;
  res_t            head;
  logic [LvlW-1:0] level;

  nrle_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .line_pixels(line_pixels)
  );

  nrle_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .in_byte    (in_byte),
    .line_pixels(line_pixels),
    .results    (results)
  );

  nrle_res_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_acc),
    .wr_data(results),
    .pop    (out_acc),
    .head   (head),
    .level  (level)
  );

  assign in_stall  = level > LvlW'(QueueDepth - 2);
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = level != '0;
  assign out_acc   = out_valid & ~out_stall;

  assign out_kind             = head.kind;
  assign out_pixel_value      = head.pixel_value;
  assign out_repeat_count     = head.repeat_count;
  assign out_text_char        = head.text_char;
  assign out_text_last        = head.text_last;
  assign out_instrument_id    = head.instrument_id;
  assign out_scan_line_number = head.scan_line_number;
  assign out_data_word        = head.data_word;
  assign out_overflow         = head.overflow;

  `NRLE_ASSERT_NOW(a_level_bound, clk, rst_n, 1'b1, level <= LvlW'(QueueDepth), "queue overfilled")
  `NRLE_ASSERT_NEXT(a_level_hold, clk, rst_n, !in_acc && !out_acc, $stable(level), "queue level moved without a request")
  `NRLE_ASSERT_NOW(a_ovf_pixel, clk, rst_n, out_valid && out_overflow, out_kind == KIND_PIXEL, "overflow on non-pixel result")
  `NRLE_ASSERT_NOW(a_last_text, clk, rst_n, out_valid && out_text_last, out_kind == KIND_TEXT, "text_last on non-text result")

endmodule

[verif/nibble_rle_line_decoder_tb.sv]
// Self-checking testbench for nibble_rle_line_decoder: byte-stream stimulus, predicted results
`timescale 1ns / 1ps

module nibble_rle_line_decoder_tb
  import nrle_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_ADDR_W-1:0] LINE_PIXELS_ADDR = CFG_ADDR_W'(4 * CFG_IDX_LINE_PIXELS);
  localparam logic [3:0] OP_UNUSED3  = 4'd3;
  localparam logic [3:0] OP_UNUSED14 = 4'd14;
  localparam logic [3:0] OP_UNUSED15 = 4'd15;

  class rle_decode_tracker;
    phase_t      phase;
    logic [3:0]  hdr_nib;
    logic [10:0] remaining;
    logic [15:0] line_cnt;
    logic [3:0]  rec_id;
    logic [31:0] ln_shift;
    logic [31:0] word_shift;
    logic        text_mark;
    logic [15:0] width;
    res_t        pending[$];
    int          errors;
    int          bytes_seen;
    int          results_seen;
    int          overflows;
    int          kind_seen[4];

    function new();
      phase = PH_HEADER;
      hdr_nib = '0;
      remaining = '0;
      line_cnt = '0;
      rec_id = '0;
      ln_shift = '0;
      word_shift = '0;
      text_mark = 1'b0;
      width = LINE_PIXELS_RST;
      errors = 0;
      bytes_seen = 0;
      results_seen = 0;
      overflows = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void add_line_end();
      res_t r;
      r = '0;
      r.kind = KIND_EOL;
      pending.push_back(r);
      line_cnt = '0;
    endfunction

    function void add_pixels(logic [3:0] code, int cnt);
      res_t r;
      r = '0;
      r.kind = KIND_PIXEL;
      r.pixel_value = 8'(int'(code) * 17);
      r.repeat_count = 9'(cnt);
      if (int'(line_cnt) + cnt <= int'(width)) begin
        line_cnt = 16'(int'(line_cnt) + cnt);
      end else begin
        r.overflow = 1'b1;
      end
      pending.push_back(r);
    endfunction

    function void decode_header(logic [7:0] b);
      logic [3:0] hi;
      hi = b[7:4];
      case (b[3:0])
        OP_EOL: add_line_end();
        OP_TEXT: begin
          text_mark = hi[0];
          hdr_nib = {1'b0, hi[3:1]};
          phase = PH_TEXT_LEN;
        end
        OP_INSTR: begin
          rec_id = hi;
          remaining = INSTR_BYTES;
          phase = PH_INSTR;
        end
        OP_RUN2, OP_RUN3, OP_RUN4, OP_RUN5, OP_RUN6, OP_RUN7:
          add_pixels(hi, int'(b[3:0]) - int'(RUN_OP_BIAS));
        OP_RUN_LONG: begin
          hdr_nib = hi;
          phase = PH_RUN_LEN;
        end
        OP_PIXEL: add_pixels(hi, 1);
        OP_RAW: begin
          remaining = 11'(int'(hi) + 1);
          phase = PH_RAW;
        end
        OP_RAW_ODD: begin
          hdr_nib = hi;
          phase = PH_RAW_ODD;
        end
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      res_t r;
      r = '0;
      bytes_seen++;
      case (phase)
        PH_HEADER: begin
          // a header on a full line closes it first
          if (b[3:0] != OP_EOL && line_cnt >= width) add_line_end();
          decode_header(b);
        end
        PH_TEXT_LEN: begin
          remaining = {hdr_nib[2:0], b};
          if (remaining != 0) begin
            phase = PH_TEXT;
          end else begin
            phase = PH_HEADER;
          end
        end
        PH_TEXT: begin
          remaining = remaining - 11'd1;
          r.kind = KIND_TEXT;
          r.text_char = b;
          r.text_last = (remaining == 0) ? text_mark : 1'b0;
          pending.push_back(r);
          if (remaining == 0) phase = PH_HEADER;
        end
        PH_INSTR: begin
          if (remaining > INSTR_WORD_BYTES) begin
            ln_shift = {b, ln_shift[31:8]};
          end else begin
            word_shift = {b, word_shift[31:8]};
          end
          remaining = remaining - 11'd1;
          if (remaining == 0) begin
            r.kind = KIND_INSTR;
            r.instrument_id = rec_id;
            r.scan_line_number = ln_shift;
            r.data_word = word_shift;
            pending.push_back(r);
            phase = PH_HEADER;
          end
        end
        PH_RUN_LEN: begin
          add_pixels(hdr_nib, int'(b) + 1);
          phase = PH_HEADER;
        end
        PH_RAW_ODD: begin
          remaining = 11'(1 + 16 * int'(hdr_nib) + int'(b[3:0]));
          add_pixels(b[7:4], 1);
          phase = PH_RAW;
        end
        PH_RAW: begin
          add_pixels(b[3:0], 1);
          add_pixels(b[7:4], 1);
          remaining = remaining - 11'd1;
          if (remaining == 0) phase = PH_HEADER;
        end
        default: phase = PH_HEADER;
      endcase
    endfunction

    function int field_diff(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v === got_v) return 0;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
      return 1;
    endfunction

    function void match_result(res_t got);
      res_t want;
      int   bad;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d", $time, got.kind);
        errors++;
        return;
      end
      want = pending.pop_front();
      results_seen++;
      kind_seen[int'(want.kind)]++;
      if (want.overflow) overflows++;
      bad = 0;
      bad += field_diff("kind", want.kind, got.kind);
      bad += field_diff("pixel_value", want.pixel_value, got.pixel_value);
      bad += field_diff("repeat_count", want.repeat_count, got.repeat_count);
      bad += field_diff("text_char", want.text_char, got.text_char);
      bad += field_diff("text_last", want.text_last, got.text_last);
      bad += field_diff("instrument_id", want.instrument_id, got.instrument_id);
      bad += field_diff("scan_line_number", want.scan_line_number, got.scan_line_number);
      bad += field_diff("data_word", want.data_word, got.data_word);
      bad += field_diff("overflow", want.overflow, got.overflow);
      if (bad != 0) errors++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_kind;
  logic [7:0]            out_pixel_value;
  logic [8:0]            out_repeat_count;
  logic [7:0]            out_text_char;
  logic                  out_text_last;
  logic [3:0]            out_instrument_id;
  logic [31:0]           out_scan_line_number;
  logic [31:0]           out_data_word;
  logic                  out_overflow;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  rle_decode_tracker tracker;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_req = 1'b0;
  int                hold_cnt = 0;
  int                cycle_cnt = 0;
  int                width_writes = 0;

  nibble_rle_line_decoder u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte              (in_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_pixel_value      (out_pixel_value),
    .out_repeat_count     (out_repeat_count),
    .out_text_char        (out_text_char),
    .out_text_last        (out_text_last),
    .out_instrument_id    (out_instrument_id),
    .out_scan_line_number (out_scan_line_number),
    .out_data_word        (out_data_word),
    .out_overflow         (out_overflow),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, tracker.pending.size());
      $display("FAIL nibble_rle_line_decoder");
      $finish;
    end
  end

  // result side: check, then choose the next stall
  always @(posedge clk) begin : result_side
    res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = kind_t'(out_kind);
      got.pixel_value = out_pixel_value;
      got.repeat_count = out_repeat_count;
      got.text_char = out_text_char;
      got.text_last = out_text_last;
      got.instrument_id = out_instrument_id;
      got.scan_line_number = out_scan_line_number;
      got.data_word = out_data_word;
      got.overflow = out_overflow;
      tracker.match_result(got);
    end
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_byte(b);
  endtask

  task automatic send_text(input int len, input logic mark);
    logic [10:0] l;
    l = 11'(len);
    send_byte({l[10:8], mark, OP_TEXT});
    send_byte(l[7:0]);
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic send_record(input logic [3:0] id, input logic [31:0] ln,
                             input logic [31:0] w);
    send_byte({id, OP_INSTR});
    for (int i = 0; i < 4; i++) send_byte(ln[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_raw(input logic [3:0] hi);
    send_byte({hi, OP_RAW});
    repeat (int'(hi) + 1) send_byte(8'($urandom));
  endtask

  task automatic send_raw_odd(input logic [3:0] hi, input logic [3:0] lo,
                              input logic [3:0] first);
    send_byte({hi, OP_RAW_ODD});
    send_byte({first, lo});
    repeat (1 + 16 * int'(hi) + int'(lo)) send_byte(8'($urandom));
  endtask

  // random byte, with text and odd-group lengths kept short
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (tracker.phase == PH_HEADER && b[3:0] == OP_TEXT) b[7:5] = 3'b000;
    if (tracker.phase == PH_HEADER && b[3:0] == OP_RAW_ODD) b[7:6] = 2'b00;
    if (tracker.phase == PH_TEXT_LEN) b[7:4] = 4'h0;
    return b;
  endfunction

  task automatic send_random_item();
    int         pick;
    logic [3:0] hi;
    pick = $urandom_range(99);
    hi = 4'($urandom);
    if (pick < 8) begin
      send_byte({hi, OP_EOL});
    end else if (pick < 16) begin
      send_text($urandom_range(0, 6), 1'($urandom));
    end else if (pick < 26) begin
      send_record(hi, $urandom, $urandom);
    end else if (pick < 40) begin
      send_byte({hi, 4'(OP_RUN2 + $urandom_range(0, 5))});
    end else if (pick < 50) begin
      send_byte({hi, OP_RUN_LONG});
      send_byte(8'($urandom));
    end else if (pick < 62) begin
      send_byte({hi, OP_PIXEL});
    end else if (pick < 72) begin
      send_raw(($urandom_range(3) == 0) ? hi : {2'b00, hi[1:0]});
    end else if (pick < 80) begin
      send_raw_odd(($urandom_range(9) == 0) ? 4'($urandom_range(1, 3)) : 4'h0,
                   4'($urandom), 4'($urandom));
    end else if (pick < 92) begin
      // cut-off sequence, then noise, then resync
      case ($urandom_range(2))
        0: begin
          send_byte({hi, OP_INSTR});
          repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
        end
        1: begin
          send_byte({hi, OP_RAW});
          send_byte(8'($urandom));
        end
        default: ;
      endcase
      repeat ($urandom_range(1, 4)) send_byte(noise_byte());
      while (tracker.phase != PH_HEADER) send_byte(noise_byte());
    end else begin
      case ($urandom_range(2))
        0: send_byte({hi, OP_UNUSED3});
        1: send_byte({hi, OP_UNUSED14});
        default: send_byte({hi, OP_UNUSED15});
      endcase
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_read(output logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LINE_PIXELS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    v = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_line_pixels(input logic [15:0] v);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LINE_PIXELS_ADDR;
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tracker.width = v;
    width_writes++;
    cfg_read(rd);
    if (rd[15:0] !== v) begin
      $display("%0t: line_pixels readback: expected %0d, got %0d", $time, v, rd[15:0]);
      tracker.errors++;
    end
  endtask

  initial begin : stimulus
    logic [31:0] rd;
    logic [15:0] w;
    int          start;
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    cfg_read(rd);
    if (rd[15:0] !== LINE_PIXELS_RST) begin
      $display("%0t: line_pixels after reset: expected %0d, got %0d", $time,
               LINE_PIXELS_RST, rd[15:0]);
      tracker.errors++;
    end

    // directed part, narrow line
    set_line_pixels(16'd10);
    send_byte({4'h0, OP_EOL});
    send_byte({4'hF, OP_RUN2});
    send_byte({4'h0, OP_RUN7});
    send_byte({4'hF, OP_PIXEL});
    send_byte({4'h3, OP_PIXEL});
    send_byte({4'hA, OP_RUN_LONG});
    send_byte(8'hFF);
    send_byte({4'h5, OP_RUN_LONG});
    send_byte(8'h00);
    send_byte({4'h0, OP_RAW_ODD});
    send_byte(8'hF0);
    send_byte(8'h21);
    send_byte({4'h2, OP_RAW});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte({4'hF, OP_UNUSED3});
    send_byte({4'h5, OP_UNUSED15});
    send_text(0, 1'b0);
    send_text(2, 1'b1);
    send_record(4'hF, 32'h1234_5678, 32'hFFFF_FFFF);
    drain();

    // text section longer than one length byte
    set_line_pixels(16'd65535);
    send_idle_pct = 18;
    stall_pct = 18;
    send_text(256, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 71;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 71;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct = 18;
        end
      endcase
      case (p)
        0: w = 16'd1;
        1: w = 16'd65535;
        2: w = 16'd24;
        3: w = 16'($urandom_range(2, 64));
        4: w = 16'd8;
        default: w = LINE_PIXELS_RST;
      endcase
      set_line_pixels(w);
      start = tracker.bytes_seen;
      while (tracker.bytes_seen < start + 12) send_random_item();
      drain();
    end

    // long output hold-off while requests keep coming
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req <= 1'b1;
    repeat (24) send_byte({4'($urandom), OP_PIXEL});
    drain();

    repeat (10) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending.size());
      tracker.errors++;
    end
    $display("Decoded %0d stream bytes into %0d checked results: %0d pixel, %0d line end,",
             tracker.bytes_seen, tracker.results_seen, tracker.kind_seen[0],
             tracker.kind_seen[1]);
    $display("%0d text, %0d record, %0d overflowed; %0d line widths, four idle mixes, one hold-off",
             tracker.kind_seen[2], tracker.kind_seen[3], tracker.overflows, width_writes);
    if (tracker.errors == 0) begin
      $display("PASS nibble_rle_line_decoder");
    end else begin
      $display("FAIL nibble_rle_line_decoder");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/nrle_pkg.sv
sv/nrle_cfg.sv
sv/nrle_parser.sv
sv/nrle_res_queue.sv
sv/nibble_rle_line_decoder.sv
verif/nibble_rle_line_decoder_tb.sv
